/* rtl/core/gyro_heading_motor_controller_top_defines.svh */
// Assertion macros for the gyro heading motor controller.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef GYRO_HEADING_MOTOR_CONTROLLER_TOP_DEFINES_SVH
`define GYRO_HEADING_MOTOR_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication
`define GHMC_CHECK_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ghmc same-cycle check failed");

// next-cycle implication
`define GHMC_CHECK_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ghmc next-cycle check failed");

`endif

/* rtl/core/ghmc_pkg.sv */
// Shared types, codes and fixed-point constants for the heading controller.
// No dependencies; imported by every module of the block.
package ghmc_pkg;

    localparam int HEADING_FRAC_BITS = 16;
    localparam int STALL_INTERVAL_MS = 1000;
    localparam int SAMPLE_PERIOD_MS  = 5;
    localparam int ONE_Q             = 1 << HEADING_FRAC_BITS;

    localparam int HEAD_W = 26;   // signed heading, |h| <= 360 deg
    localparam int INC_W  = 22;   // signed per-tick increment
    localparam int ERR_W  = 28;   // signed heading error
    localparam int MAG_W  = 26;   // error magnitude
    localparam int TERM_W = 24;   // clamped drive term magnitude
    localparam int SUM_W  = 26;   // signed duty sum

    // inc = round(|d| * 5 * 2^16 / 16000) = floor((512*|d| + 12) / 25)
    localparam int INC_MUL   = SAMPLE_PERIOD_MS * ONE_Q / 640;
    localparam int INC_BIAS  = 12;
    localparam int INC_DIV   = 25;
    localparam int INC_SHIFT = 30;
    localparam logic [25:0] INC_RECIP = 26'(((1 << INC_SHIFT) + INC_DIV - 1) / INC_DIV);

    // term = floor(|err| * 85 / 24); /24 done as >>3 then reciprocal of 3
    localparam int DIV3_SHIFT = 26;
    localparam logic [24:0] DIV3_RECIP = 25'(((1 << DIV3_SHIFT) + 2) / 3);

    localparam logic signed [HEAD_W:0] FULL_TURN_Q = (HEAD_W+1)'(360 * ONE_Q);
    localparam logic [HEAD_W:0]        STALL_MIN_Q = (HEAD_W+1)'(5 * ONE_Q);
    localparam logic [MAG_W+2:0]       ON_TARGET_Q = (MAG_W+3)'(ONE_Q);

    localparam logic [TERM_W-1:0] STR_LO_Q  = TERM_W'(10 * ONE_Q);
    localparam logic [TERM_W-1:0] STR_HI_Q  = TERM_W'(160 * ONE_Q);
    localparam logic [TERM_W-1:0] TURN_LO_Q = TERM_W'(80 * ONE_Q);
    localparam logic [TERM_W-1:0] TURN_HI_Q = TERM_W'(120 * ONE_Q);
    localparam logic [32:0] STR_LO_V  = 33'(10 * ONE_Q * 24);
    localparam logic [32:0] STR_HI_V  = 33'((160 * ONE_Q + 1) * 24);
    localparam logic [32:0] TURN_LO_V = 33'(80 * ONE_Q * 24);
    localparam logic [32:0] TURN_HI_V = 33'((120 * ONE_Q + 1) * 24);

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    localparam logic [2:0] CAUSE_NONE    = 3'd0;
    localparam logic [2:0] CAUSE_TIMEOUT = 3'd1;
    localparam logic [2:0] CAUSE_TARGET  = 3'd2;
    localparam logic [2:0] CAUSE_STALL   = 3'd3;
    localparam logic [2:0] CAUSE_CMD     = 3'd4;

    localparam logic [2:0] REG_MOTION_MODE  = 3'd0;
    localparam logic [2:0] REG_DRIVE_FWD    = 3'd1;
    localparam logic [2:0] REG_BASE_SPEED   = 3'd2;
    localparam logic [2:0] REG_DURATION     = 3'd3;
    localparam logic [2:0] REG_TARGET_ANGLE = 3'd4;
    localparam logic [2:0] REG_GYRO_BIAS    = 3'd5;

    typedef enum logic [1:0] {
        MODE_OFF      = 2'd0,
        MODE_STRAIGHT = 2'd1,
        MODE_TURN     = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        DRV_NONE     = 2'd0,
        DRV_STRAIGHT = 2'd1,
        DRV_TURN     = 2'd2
    } drv_kind_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] gyro_rate;
        logic [31:0]        now_ms;
    } req_t;

    typedef struct packed {
        logic [7:0] left_duty;
        logic       left_reverse;
        logic [7:0] right_duty;
        logic       right_reverse;
        logic       running;
        logic [2:0] stop_cause;
    } rsp_t;

    typedef struct packed {
        logic               motion_mode;
        logic               drive_forward;
        logic [7:0]         base_speed;
        logic [31:0]        move_duration_ms;
        logic signed [13:0] target_angle;
        logic signed [15:0] gyro_bias;
    } cfg_t;

    typedef struct packed {
        logic [1:0]              op;
        logic [31:0]             now_ms;
        logic signed [INC_W-1:0] inc;
    } stg1_t;

    typedef struct packed {
        drv_kind_t        kind;
        logic             running;
        logic [2:0]       stop_cause;
        logic [MAG_W-1:0] err_mag;
        logic             err_pos;
    } trk_t;

    function automatic logic [7:0] sat_duty(input logic signed [SUM_W-1:0] v);
        logic [7:0] d;
        if (v[SUM_W-1])
        begin
            d = 8'd0;
        end
        else if (v[SUM_W-2])
        begin
            d = 8'd255;
        end
        else
        begin
            d = v[HEADING_FRAC_BITS +: 8];
        end
        return d;
    endfunction

endpackage

/* rtl/core/ghmc_track.sv */
// Motion state tracker: heading integration, wrap, timeout, target and stall checks.
// Depends on ghmc_pkg. Updates its state once per request moving into stage 2.
module ghmc_track (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           upd,
    input  ghmc_pkg::stg1_t s1,
    input  ghmc_pkg::cfg_t  cfg,
    output ghmc_pkg::trk_t  trk
);
    import ghmc_pkg::*;

    mode_t                    mode_reg, mode_next;
    logic signed [HEAD_W-1:0] heading_reg, heading_next;
    logic [31:0]              start_reg, start_next;
    logic [31:0]              chk_time_reg, chk_time_next;
    logic signed [HEAD_W-1:0] chk_head_reg, chk_head_next;

    logic signed [HEAD_W:0]   h_sum;
    logic signed [HEAD_W:0]   h_wrap;
    logic signed [HEAD_W-1:0] h_new;
    logic signed [ERR_W-1:0]  str_err;
    logic signed [ERR_W-1:0]  turn_err;
    logic signed [ERR_W-1:0]  turn_mag_s;
    logic [MAG_W-1:0]         turn_mag;
    logic                     on_target;
    logic [31:0]              run_time;
    logic [31:0]              chk_time;
    logic                     chk_due;
    logic signed [HEAD_W:0]   dh;
    logic [HEAD_W:0]          dh_mag;
    logic                     slow;
    logic signed [ERR_W-1:0]  err_sel;
    logic signed [ERR_W-1:0]  err_abs;
    logic [2:0]               cause;
    drv_kind_t                kind;

    always_comb
    begin
        h_sum = (HEAD_W+1)'(heading_reg) + (HEAD_W+1)'(s1.inc);
        if (h_sum > FULL_TURN_Q)
        begin
            h_wrap = h_sum - FULL_TURN_Q;
        end
        else if (h_sum < -FULL_TURN_Q)
        begin
            h_wrap = h_sum + FULL_TURN_Q;
        end
        else
        begin
            h_wrap = h_sum;
        end
        h_new = h_wrap[HEAD_W-1:0];

        str_err    = -ERR_W'(h_new);
        turn_err   = ERR_W'($signed({cfg.target_angle, (HEADING_FRAC_BITS-4)'(0)}))
                   - ERR_W'(h_new);
        turn_mag_s = turn_err[ERR_W-1] ? -turn_err : turn_err;
        turn_mag   = turn_mag_s[MAG_W-1:0];
        on_target  = ((MAG_W+3)'(turn_mag) * (MAG_W+3)'(5)) <= ON_TARGET_Q;

        run_time = s1.now_ms - start_reg;
        chk_time = s1.now_ms - chk_time_reg;
        chk_due  = chk_time > 32'(STALL_INTERVAL_MS);
        dh       = (HEAD_W+1)'(h_new) - (HEAD_W+1)'(chk_head_reg);
        dh_mag   = dh[HEAD_W] ? (HEAD_W+1)'(-dh) : (HEAD_W+1)'(dh);
        slow     = dh_mag < STALL_MIN_Q;
    end

    always_comb
    begin
        mode_next     = mode_reg;
        heading_next  = heading_reg;
        start_next    = start_reg;
        chk_time_next = chk_time_reg;
        chk_head_next = chk_head_reg;
        cause         = CAUSE_NONE;
        kind          = DRV_NONE;
        err_sel       = '0;

        priority if (s1.op == OP_START)
        begin
            heading_next  = '0;
            mode_next     = cfg.motion_mode ? MODE_TURN : MODE_STRAIGHT;
            start_next    = s1.now_ms;
            chk_time_next = s1.now_ms;
            chk_head_next = '0;
        end
        else if (s1.op == OP_STOP)
        begin
            mode_next = MODE_OFF;
            cause     = CAUSE_CMD;
        end
        else if (mode_reg == MODE_STRAIGHT)
        begin
            heading_next = h_new;
            if (run_time > cfg.move_duration_ms)
            begin
                mode_next = MODE_OFF;
                cause     = CAUSE_TIMEOUT;
            end
            else
            begin
                kind    = DRV_STRAIGHT;
                err_sel = str_err;
            end
        end
        else if (mode_reg == MODE_TURN)
        begin
            heading_next = h_new;
            kind         = DRV_TURN;
            err_sel      = turn_err;
            if (on_target)
            begin
                mode_next = MODE_OFF;
                cause     = CAUSE_TARGET;
            end
            if (chk_due)
            begin
                if (slow && (cause == CAUSE_NONE))
                begin
                    mode_next = MODE_OFF;
                    cause     = CAUSE_STALL;
                end
                chk_head_next = h_new;
                chk_time_next = s1.now_ms;
            end
        end
        else
        begin
            // idle tick: nothing moves
        end

        if (mode_next == MODE_OFF)
        begin
            kind = DRV_NONE;
        end

        err_abs        = err_sel[ERR_W-1] ? -err_sel : err_sel;
        trk.kind       = kind;
        trk.running    = (mode_next != MODE_OFF);
        trk.stop_cause = cause;
        trk.err_mag    = err_abs[MAG_W-1:0];
        trk.err_pos    = !err_sel[ERR_W-1] && (err_sel != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_OFF;
            heading_reg  <= '0;
            start_reg    <= '0;
            chk_time_reg <= '0;
            chk_head_reg <= '0;
        end
        else if (upd)
        begin
            mode_reg     <= mode_next;
            heading_reg  <= heading_next;
            start_reg    <= start_next;
            chk_time_reg <= chk_time_next;
            chk_head_reg <= chk_head_next;
        end
    end

endmodule

/* rtl/core/ghmc_drive.sv */
// Drive term and wheel mix: gain, magnitude clamp and duty saturation.
// Depends on ghmc_pkg. One internal register between the gain and divide steps.
module ghmc_drive (
    input  logic           clk,
    input  logic           load,
    input  ghmc_pkg::trk_t  trk,
    input  ghmc_pkg::cfg_t  cfg,
    output ghmc_pkg::rsp_t  rsp
);
    import ghmc_pkg::*;

    drv_kind_t   kind_reg;
    logic        running_reg;
    logic [2:0]  cause_reg;
    logic        pos_reg;
    logic        below_reg;
    logic        above_reg;
    logic [27:0] gain_reg;

    logic [32:0]             gain;
    logic [32:0]             lo_v;
    logic [32:0]             hi_v;
    logic [24:0]             gain_div8;
    logic [49:0]             div_prod;
    logic [TERM_W-1:0]       quot;
    logic [TERM_W-1:0]       lo_q;
    logic [TERM_W-1:0]       hi_q;
    logic [TERM_W-1:0]       term;
    logic signed [SUM_W-1:0] speed;
    logic signed [SUM_W-1:0] sum_plus;
    logic signed [SUM_W-1:0] sum_minus;
    logic [7:0]              duty_base;
    logic [7:0]              duty_plus;
    logic [7:0]              duty_minus;

    always_comb
    begin
        gain = 33'(trk.err_mag) * 33'(85);
        lo_v = (trk.kind == DRV_TURN) ? TURN_LO_V : STR_LO_V;
        hi_v = (trk.kind == DRV_TURN) ? TURN_HI_V : STR_HI_V;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg    <= trk.kind;
            running_reg <= trk.running;
            cause_reg   <= trk.stop_cause;
            pos_reg     <= trk.err_pos;
            below_reg   <= gain < lo_v;
            above_reg   <= gain >= hi_v;
            gain_reg    <= gain[27:0];
        end
    end

    always_comb
    begin
        gain_div8 = gain_reg[27:3];
        div_prod  = 50'(gain_div8) * 50'(DIV3_RECIP);
        quot      = div_prod[DIV3_SHIFT +: TERM_W];
        lo_q      = (kind_reg == DRV_TURN) ? TURN_LO_Q : STR_LO_Q;
        hi_q      = (kind_reg == DRV_TURN) ? TURN_HI_Q : STR_HI_Q;
        priority if (below_reg)
        begin
            term = lo_q;
        end
        else if (above_reg)
        begin
            term = hi_q;
        end
        else
        begin
            term = quot;
        end

        speed      = SUM_W'({cfg.base_speed, HEADING_FRAC_BITS'(0)});
        sum_plus   = speed + SUM_W'(term);
        sum_minus  = speed - SUM_W'(term);
        duty_base  = sat_duty(speed);
        duty_plus  = sat_duty(sum_plus);
        duty_minus = sat_duty(sum_minus);

        rsp.running    = running_reg;
        rsp.stop_cause = cause_reg;
        unique case (kind_reg)
            DRV_STRAIGHT:
            begin
                if (cfg.drive_forward)
                begin
                    rsp.left_duty     = pos_reg ? duty_minus : duty_plus;
                    rsp.right_duty    = pos_reg ? duty_plus : duty_minus;
                    rsp.left_reverse  = 1'b1;
                    rsp.right_reverse = 1'b0;
                end
                else
                begin
                    rsp.left_duty     = pos_reg ? duty_plus : duty_base;
                    rsp.right_duty    = pos_reg ? duty_base : duty_plus;
                    rsp.left_reverse  = 1'b0;
                    rsp.right_reverse = 1'b1;
                end
            end
            DRV_TURN:
            begin
                rsp.left_duty     = term[HEADING_FRAC_BITS +: 8];
                rsp.right_duty    = term[HEADING_FRAC_BITS +: 8];
                rsp.left_reverse  = !pos_reg;
                rsp.right_reverse = !pos_reg;
            end
            default:
            begin
                rsp.left_duty     = 8'd0;
                rsp.right_duty    = 8'd0;
                rsp.left_reverse  = 1'b0;
                rsp.right_reverse = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/gyro_heading_motor_controller_top.sv */
// Gyro heading motor controller: top level with config port and request pipeline.
// Depends on ghmc_pkg, ghmc_track, ghmc_drive and the _defines.svh macros.
//
// Usage:
//  - Requests (req) enter on req_valid/req_stall: op tick, start or stop, with the
//    gyro rate and millisecond time stamp. Accepted when req_valid && !req_stall.
//  - One response (rsp) per request on rsp_valid/rsp_stall, in order.
//  - Requests pass through four register stages (the first loaded at accept):
//    rate scaling, state update, gain, then divide/clamp/mix into the output
//    register, which drives rsp_valid.
//  - Throughput is one request per cycle while rsp_stall is low; the heading/mode
//    state loop closes in a single stage, so back-to-back ticks need no spacing.
//  - When rsp_stall holds, the four stages fill one by one; req_stall rises
//    only once every stage holds a request.
//  - Write registers over the APB-style port only while no request is in flight
//    (not enforced by the block); pready is tied high, reads return the stored value.
//  - Reset clears motion state (off, heading zero) and loads register defaults
//    (drive_forward 1, all else 0); the pipeline comes up empty.
module gyro_heading_motor_controller_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             req_valid,
    output logic             req_stall,
    input  ghmc_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output ghmc_pkg::rsp_t   rsp
);
    import ghmc_pkg::*;

    `include "gyro_heading_motor_controller_top_defines.svh"

    cfg_t  cfg_reg;
    logic  v1_reg;
    logic  v2_reg;
    logic  v3_reg;
    logic  v4_reg;
    stg1_t s1_reg;
    trk_t  s2_reg;
    rsp_t  rsp_reg;

    logic [2:0]           reg_idx;
    logic                 cfg_wr;
    logic                 rdy1;
    logic                 rdy2;
    logic                 rdy3;
    logic                 rdy4;
    logic                 accept;
    logic signed [16:0]   rate_diff;
    logic signed [16:0]   rate_neg;
    logic [15:0]          rate_mag;
    logic [24:0]          scaled;
    logic [50:0]          inc_prod;
    logic [INC_W-2:0]     inc_mag;
    stg1_t                s1_next;
    trk_t                 trk;
    rsp_t                 mix;
    logic                 rsp_quiet;

    // config port
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_idx)
            REG_MOTION_MODE:  prdata = {31'b0, cfg_reg.motion_mode};
            REG_DRIVE_FWD:    prdata = {31'b0, cfg_reg.drive_forward};
            REG_BASE_SPEED:   prdata = {24'b0, cfg_reg.base_speed};
            REG_DURATION:     prdata = cfg_reg.move_duration_ms;
            REG_TARGET_ANGLE: prdata = {18'b0, cfg_reg.target_angle};
            REG_GYRO_BIAS:    prdata = {16'b0, cfg_reg.gyro_bias};
            default:          prdata = 32'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.motion_mode      <= 1'b0;
            cfg_reg.drive_forward    <= 1'b1;
            cfg_reg.base_speed       <= '0;
            cfg_reg.move_duration_ms <= '0;
            cfg_reg.target_angle     <= '0;
            cfg_reg.gyro_bias        <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_MOTION_MODE:  cfg_reg.motion_mode      <= pwdata[0];
                REG_DRIVE_FWD:    cfg_reg.drive_forward    <= pwdata[0];
                REG_BASE_SPEED:   cfg_reg.base_speed       <= pwdata[7:0];
                REG_DURATION:     cfg_reg.move_duration_ms <= pwdata;
                REG_TARGET_ANGLE: cfg_reg.target_angle     <= pwdata[13:0];
                REG_GYRO_BIAS:    cfg_reg.gyro_bias        <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    // pipeline flow
    assign rdy4      = !v4_reg || !rsp_stall;
    assign rdy3      = !v3_reg || rdy4;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign req_stall = !rdy1;
    assign accept    = req_valid && rdy1;
    assign rsp_valid = v4_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= req_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // stage 1: bias-corrected rate to rounded heading increment
    always_comb
    begin
        rate_diff = 17'({req.gyro_rate[15], req.gyro_rate})
                  - 17'({cfg_reg.gyro_bias[15], cfg_reg.gyro_bias});
        rate_neg  = -rate_diff;
        rate_mag  = rate_diff[16] ? rate_neg[15:0] : rate_diff[15:0];
        scaled    = 25'(rate_mag) * 25'(INC_MUL) + 25'(INC_BIAS);
        inc_prod  = 51'(scaled) * 51'(INC_RECIP);
        inc_mag   = inc_prod[INC_SHIFT +: INC_W-1];
        s1_next.op     = req.op;
        s1_next.now_ms = req.now_ms;
        s1_next.inc    = rate_diff[16] ? -INC_W'(inc_mag) : INC_W'(inc_mag);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (v1_reg && rdy2)
        begin
            s2_reg <= trk;
        end
        if (v3_reg && rdy4)
        begin
            rsp_reg <= mix;
        end
    end

    // stage 2: motion state
    ghmc_track u_track (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (v1_reg && rdy2),
        .s1    (s1_reg),
        .cfg   (cfg_reg),
        .trk   (trk)
    );

    // stages 3 and 4: drive term and wheel mix
    ghmc_drive u_drive (
        .clk  (clk),
        .load (v2_reg && rdy3),
        .trk  (s2_reg),
        .cfg  (cfg_reg),
        .rsp  (mix)
    );

    assign rsp_quiet = !rsp.running && (rsp.left_duty == 8'd0) && (rsp.right_duty == 8'd0);

    `GHMC_CHECK_NOW(a_stall_full, req_stall, (v1_reg && v2_reg && v3_reg && v4_reg))
    `GHMC_CHECK_NEXT(a_accept_fills, accept, v1_reg)
    `GHMC_CHECK_NOW(a_stop_idle, (rsp_valid && (rsp.stop_cause != CAUSE_NONE)), rsp_quiet)

endmodule

/* test/tb_gyro_heading_motor_controller_top.sv */
// Self-checking testbench for gyro_heading_motor_controller_top: directed table, then random
// straight, turn and noise requests with random idling, checked against a local predictor.
// Depends on ghmc_pkg and the gyro_heading_motor_controller_top RTL.
`timescale 1ns / 1ps

module tb_gyro_heading_motor_controller_top;
    import ghmc_pkg::*;

    localparam int N_ITEMS        = 1050;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam longint Q = longint'(ONE_Q);

    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [31:0] val;
        req_t        r;
        bit          pinned;
        rsp_t        want;
    } step_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp;

    // predictor state
    cfg_t        shadow_cfg;
    mode_t       act_mode;
    longint      hdg;
    logic [31:0] start_ms;
    logic [31:0] chk_ms;
    longint      chk_hdg;

    rsp_t        expected_drive[$];
    step_row_t   plan[$];
    rsp_t        want_drive;
    int          mism = 0;
    int          sent = 0;
    int          quiet_cycles = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          idle_by_phase[4] = '{0, 50, 0, 34};
    int          stall_by_phase[4] = '{0, 0, 50, 34};

    gyro_heading_motor_controller_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint abs_q(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp_gain(input longint err, input longint lo, input longint hi);
        longint t;
        longint m;
        t = (err * 85) / 24;
        m = abs_q(t);
        if (m < lo * Q)
            m = lo * Q;
        if (m > hi * Q)
            m = hi * Q;
        return (err > 0) ? m : -m;
    endfunction

    function automatic logic [7:0] sat_wheel(input longint v);
        if (v < 0)
            v = 0;
        if (v > 255 * Q)
            v = 255 * Q;
        return 8'(v >>> HEADING_FRAC_BITS);
    endfunction

    function automatic void integrate_rate(input logic signed [15:0] rate);
        longint num;
        longint inc;
        longint h;
        num = (longint'($signed(rate)) - longint'($signed(shadow_cfg.gyro_bias)))
              * SAMPLE_PERIOD_MS * Q;
        inc = (abs_q(num) + 8000) / 16000;
        h = hdg + ((num < 0) ? -inc : inc);
        while (h > 360 * Q)
            h -= 360 * Q;
        while (h < -360 * Q)
            h += 360 * Q;
        hdg = h;
    endfunction

    function automatic rsp_t drive_step(input req_t r);
        rsp_t        o;
        longint      err;
        longint      t;
        longint      sp;
        logic [31:0] dt;
        logic [7:0]  d;
        o = '0;
        if (r.op == OP_START)
        begin
            hdg = 0;
            act_mode = shadow_cfg.motion_mode ? MODE_TURN : MODE_STRAIGHT;
            start_ms = r.now_ms;
            chk_ms = r.now_ms;
            chk_hdg = 0;
        end
        else if (r.op == OP_STOP)
        begin
            act_mode = MODE_OFF;
            o.stop_cause = CAUSE_CMD;
        end
        else if (act_mode == MODE_STRAIGHT)
        begin
            integrate_rate(r.gyro_rate);
            dt = r.now_ms - start_ms;
            if (dt > shadow_cfg.move_duration_ms)
            begin
                act_mode = MODE_OFF;
                o.stop_cause = CAUSE_TIMEOUT;
            end
            else
            begin
                t = clamp_gain(-hdg, 10, 160);
                sp = longint'(shadow_cfg.base_speed) * Q;
                if (shadow_cfg.drive_forward)
                begin
                    o.left_duty = sat_wheel(sp - t);
                    o.left_reverse = 1'b1;
                    o.right_duty = sat_wheel(sp + t);
                    o.right_reverse = 1'b0;
                end
                else
                begin
                    o.left_duty = sat_wheel(sp + ((t > 0) ? t : 0));
                    o.left_reverse = 1'b0;
                    o.right_duty = sat_wheel(sp + ((t < 0) ? -t : 0));
                    o.right_reverse = 1'b1;
                end
            end
        end
        else if (act_mode == MODE_TURN)
        begin
            integrate_rate(r.gyro_rate);
            err = longint'($signed(shadow_cfg.target_angle)) * (Q >>> 4) - hdg;
            t = clamp_gain(err, 80, 120);
            d = 8'(abs_q(t) >>> HEADING_FRAC_BITS);
            o.left_duty = d;
            o.right_duty = d;
            o.left_reverse = (t > 0) ? 1'b0 : 1'b1;
            o.right_reverse = o.left_reverse;
            if (abs_q(err) * 5 <= Q)
            begin
                act_mode = MODE_OFF;
                o.stop_cause = CAUSE_TARGET;
            end
            dt = r.now_ms - chk_ms;
            if (dt > STALL_INTERVAL_MS)
            begin
                // on target wins over stalled
                if (abs_q(hdg - chk_hdg) < 5 * Q && o.stop_cause == CAUSE_NONE)
                begin
                    act_mode = MODE_OFF;
                    o.stop_cause = CAUSE_STALL;
                end
                chk_hdg = hdg;
                chk_ms = r.now_ms;
            end
        end
        if (act_mode == MODE_OFF)
        begin
            o.left_duty = '0;
            o.left_reverse = 1'b0;
            o.right_duty = '0;
            o.right_reverse = 1'b0;
        end
        o.running = (act_mode != MODE_OFF);
        return o;
    endfunction

    function automatic string drive_str(input rsp_t v);
        return $sformatf("L=%0d/%0d R=%0d/%0d run=%0d cause=%0d", v.left_duty,
                         v.left_reverse, v.right_duty, v.right_reverse, v.running,
                         v.stop_cause);
    endfunction

    function automatic rsp_t mk_drive(input logic [7:0] ld, input logic lr,
                                      input logic [7:0] rd, input logic rr,
                                      input logic run, input logic [2:0] cause);
        rsp_t v;
        v.left_duty = ld;
        v.left_reverse = lr;
        v.right_duty = rd;
        v.right_reverse = rr;
        v.running = run;
        v.stop_cause = cause;
        return v;
    endfunction

    function automatic step_row_t cfg_row(input logic [2:0] idx, input logic [31:0] val);
        step_row_t s;
        s = '{default: '0};
        s.is_cfg = 1'b1;
        s.idx = idx;
        s.val = val;
        return s;
    endfunction

    function automatic step_row_t req_row(input logic [1:0] op, input logic signed [15:0] rate,
                                          input logic [31:0] now);
        step_row_t s;
        s = '{default: '0};
        s.r.op = op;
        s.r.gyro_rate = rate;
        s.r.now_ms = now;
        return s;
    endfunction

    function automatic step_row_t pin_row(input logic [1:0] op, input logic signed [15:0] rate,
                                          input logic [31:0] now, input rsp_t want);
        step_row_t s;
        s = req_row(op, rate, now);
        s.pinned = 1'b1;
        s.want = want;
        return s;
    endfunction

    task automatic send_req(input req_t r, input bit pinned, input rsp_t want);
        rsp_t pred;
        if ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (req_stall);
        pred = drive_step(r);
        expected_drive.push_back(pinned ? want : pred);
        sent++;
    endtask

    // hold off until every outstanding request has its response
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (expected_drive.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_MOTION_MODE:  shadow_cfg.motion_mode = val[0];
            REG_DRIVE_FWD:    shadow_cfg.drive_forward = val[0];
            REG_BASE_SPEED:   shadow_cfg.base_speed = val[7:0];
            REG_DURATION:     shadow_cfg.move_duration_ms = val;
            REG_TARGET_ANGLE: shadow_cfg.target_angle = val[13:0];
            REG_GYRO_BIAS:    shadow_cfg.gyro_bias = val[15:0];
            default: ;
        endcase
    endtask

    task automatic program_motion(input logic mode, input logic fwd, input int base,
                                  input logic [31:0] dur, input int tgt, input int bias);
        wait_idle();
        write_reg(REG_MOTION_MODE, 32'(mode));
        write_reg(REG_DRIVE_FWD, 32'(fwd));
        write_reg(REG_BASE_SPEED, 32'(base));
        write_reg(REG_DURATION, dur);
        write_reg(REG_TARGET_ANGLE, 32'(tgt));
        write_reg(REG_GYRO_BIAS, 32'(bias));
    endtask

    task automatic send_plain(input logic [1:0] op, input int rate, input logic [31:0] now);
        req_t r;
        r.op = op;
        r.gyro_rate = 16'(rate);
        r.now_ms = now;
        send_req(r, 1'b0, '0);
    endtask

    task automatic run_straight();
        int          base;
        int          n;
        int          rate;
        logic [31:0] dur;
        logic [31:0] now;
        base = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 255 : 0) : $urandom_range(255);
        case ($urandom_range(9))
            0:       dur = 32'd0;
            1:       dur = 32'hFFFF_FFFF;
            default: dur = $urandom_range(250, 20);
        endcase
        program_motion(1'b0, 1'($urandom_range(1)), base, dur,
                       int'($urandom_range(11520)) - 5760,
                       ($urandom_range(7) == 0) ? int'($urandom) : int'($urandom_range(400)) - 200);
        now = $urandom;
        send_plain(OP_START, int'($urandom), now);
        n = $urandom_range(40, 4);
        for (int i = 0; i < n; i++)
        begin
            now += ($urandom_range(7) == 0) ? $urandom_range(300) : 5;
            rate = ($urandom_range(3) == 0) ? int'($urandom) : int'($urandom_range(6000)) - 3000;
            send_plain(($urandom_range(15) == 0) ? OP_SPARE : OP_TICK, rate, now);
            if (act_mode == MODE_OFF && $urandom_range(3) != 0)
                break;
        end
        if ($urandom_range(2) == 0)
            send_plain(OP_STOP, int'($urandom), now + 1);
    endtask

    task automatic run_turn();
        int          tgt;
        int          mag;
        int          dir;
        int          n;
        int          rate;
        logic [31:0] now;
        tgt = ($urandom_range(4) == 0) ? int'($urandom_range(11520)) - 5760
                                       : int'($urandom_range(400)) - 200;
        program_motion(1'b1, 1'($urandom_range(1)), $urandom_range(255), $urandom,
                       tgt, int'($urandom_range(200)) - 100);
        dir = (tgt >= 0) ? 1 : -1;
        mag = $urandom_range(800, 16);
        now = $urandom;
        send_plain(OP_START, int'($urandom), now);
        n = $urandom_range(120, 10);
        for (int i = 0; i < n; i++)
        begin
            now += ($urandom_range(19) == 0) ? $urandom_range(1500, 1001) : 5;
            case ($urandom_range(9))
                0:       rate = int'($urandom);
                1:       rate = dir * int'($urandom_range(40));
                default: rate = dir * mag;
            endcase
            send_plain(($urandom_range(15) == 0) ? OP_SPARE : OP_TICK, rate, now);
            if (act_mode == MODE_OFF && $urandom_range(3) != 0)
                break;
        end
        if ($urandom_range(3) == 0)
            send_plain(OP_STOP, int'($urandom), now + 1);
    endtask

    task automatic run_noise();
        int n;
        n = $urandom_range(15, 5);
        for (int i = 0; i < n; i++)
            send_plain(2'($urandom_range(3)), int'($urandom), $urandom);
    endtask

    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall)
        begin
            if (expected_drive.size() == 0)
            begin
                if (mism < 10)
                    $display("unexpected response: %s", drive_str(rsp));
                mism++;
            end
            else
            begin
                want_drive = expected_drive.pop_front();
                if (rsp.left_duty !== want_drive.left_duty
                    || rsp.left_reverse !== want_drive.left_reverse
                    || rsp.right_duty !== want_drive.right_duty
                    || rsp.right_reverse !== want_drive.right_reverse
                    || rsp.running !== want_drive.running
                    || rsp.stop_cause !== want_drive.stop_cause)
                begin
                    if (mism < 10)
                        $display("mismatch: expected %s got %s", drive_str(want_drive),
                                 drive_str(rsp));
                    mism++;
                end
            end
        end
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        do @(posedge clk); while (quiet_cycles < WATCHDOG_LIMIT);
        $display("FAIL gyro_heading_motor_controller_top");
        $finish;
    end

    initial
    begin
        shadow_cfg = '0;
        shadow_cfg.drive_forward = 1'b1;
        act_mode = MODE_OFF;
        hdg = 0;
        start_ms = '0;
        chk_ms = '0;
        chk_hdg = 0;

        // reset defaults: straight, forward, speed 0, duration 0
        plan.push_back(pin_row(OP_TICK, 16'sh7FFF, 32'd0, mk_drive(0, 0, 0, 0, 0, CAUSE_NONE)));
        plan.push_back(pin_row(OP_SPARE, 16'sh8000, 32'hFFFF_FFFF,
                               mk_drive(0, 0, 0, 0, 0, CAUSE_NONE)));
        plan.push_back(pin_row(OP_STOP, 16'sd0, 32'd5, mk_drive(0, 0, 0, 0, 0, CAUSE_CMD)));
        plan.push_back(pin_row(OP_START, 16'sd0, 32'd100, mk_drive(0, 0, 0, 0, 1, CAUSE_NONE)));
        plan.push_back(req_row(OP_TICK, 16'sd0, 32'd100));
        plan.push_back(pin_row(OP_TICK, 16'sd0, 32'd101, mk_drive(0, 0, 0, 0, 0, CAUSE_TIMEOUT)));
        // backward, full speed, longest duration, time stamp wrap
        plan.push_back(cfg_row(REG_BASE_SPEED, 32'd255));
        plan.push_back(cfg_row(REG_DRIVE_FWD, 32'd0));
        plan.push_back(cfg_row(REG_DURATION, 32'hFFFF_FFFF));
        plan.push_back(pin_row(OP_START, 16'sd0, 32'hFFFF_FFF0,
                               mk_drive(0, 0, 0, 0, 1, CAUSE_NONE)));
        plan.push_back(req_row(OP_TICK, 16'sh7FFF, 32'hFFFF_FFF5));
        plan.push_back(req_row(OP_TICK, 16'sh8000, 32'd4));
        plan.push_back(cfg_row(REG_GYRO_BIAS, 32'hFFFF_8000));
        plan.push_back(req_row(OP_TICK, 16'sh7FFF, 32'd9));
        plan.push_back(cfg_row(REG_GYRO_BIAS, 32'h0000_7FFF));
        plan.push_back(req_row(OP_TICK, 16'sh8000, 32'd14));
        plan.push_back(pin_row(OP_STOP, 16'sd0, 32'd15, mk_drive(0, 0, 0, 0, 0, CAUSE_CMD)));
        // turn: largest target, then stalled
        plan.push_back(cfg_row(REG_MOTION_MODE, 32'd1));
        plan.push_back(cfg_row(REG_GYRO_BIAS, 32'd0));
        plan.push_back(cfg_row(REG_TARGET_ANGLE, 32'd5760));
        plan.push_back(pin_row(OP_START, 16'sd0, 32'd0, mk_drive(0, 0, 0, 0, 1, CAUSE_NONE)));
        plan.push_back(pin_row(OP_TICK, 16'sd0, 32'd5, mk_drive(120, 0, 120, 0, 1, CAUSE_NONE)));
        plan.push_back(pin_row(OP_TICK, 16'sd0, 32'd1001, mk_drive(0, 0, 0, 0, 0, CAUSE_STALL)));
        // most negative target
        plan.push_back(cfg_row(REG_TARGET_ANGLE, 32'hFFFF_E980));
        plan.push_back(req_row(OP_START, 16'sd0, 32'd0));
        plan.push_back(req_row(OP_TICK, 16'sh8000, 32'd5));
        plan.push_back(req_row(OP_TICK, 16'sh7FFF, 32'd10));
        plan.push_back(pin_row(OP_STOP, 16'sd0, 32'd11, mk_drive(0, 0, 0, 0, 0, CAUSE_CMD)));
        // zero error on target; just inside and just outside the 0.2 degree window
        plan.push_back(cfg_row(REG_TARGET_ANGLE, 32'd0));
        plan.push_back(req_row(OP_START, 16'sd0, 32'd50));
        plan.push_back(pin_row(OP_TICK, 16'sd0, 32'd55, mk_drive(0, 0, 0, 0, 0, CAUSE_TARGET)));
        plan.push_back(cfg_row(REG_TARGET_ANGLE, 32'd3));
        plan.push_back(req_row(OP_START, 16'sd0, 32'd0));
        plan.push_back(req_row(OP_TICK, 16'sd0, 32'd5));
        plan.push_back(cfg_row(REG_TARGET_ANGLE, 32'd4));
        plan.push_back(req_row(OP_START, 16'sd0, 32'd0));
        plan.push_back(req_row(OP_TICK, 16'sd0, 32'd5));
        plan.push_back(req_row(OP_SPARE, 16'sd0, 32'd1006));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        idle_pct = idle_by_phase[3];
        stall_pct = stall_by_phase[3];
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_idle();
                write_reg(plan[i].idx, plan[i].val);
            end
            else
            begin
                send_req(plan[i].r, plan[i].pinned, plan[i].want);
            end
        end

        for (int seq = 0; sent < N_ITEMS; seq++)
        begin
            idle_pct = idle_by_phase[(seq / 4) % 4];
            stall_pct = stall_by_phase[(seq / 4) % 4];
            case ($urandom_range(9))
                0, 1, 2, 3: run_straight();
                4, 5, 6, 7: run_turn();
                default:    run_noise();
            endcase
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mism == 0 && expected_drive.size() == 0)
            $display("PASS gyro_heading_motor_controller_top");
        else
            $display("FAIL gyro_heading_motor_controller_top");
        $finish;
    end

endmodule
